// File: sv/lqrsc_pkg.sv
// ----------------------------------------------------------------------------
// lqrsc_pkg
// Shared constants, register indexes and control types of the speed controller.
// ----------------------------------------------------------------------------
package lqrsc_pkg;

   localparam int FRAC_BITS_DEFAULT    = 12;
   localparam int SIGNAL_WIDTH_DEFAULT = 24;
   localparam int MASS_WIDTH           = 16;
   localparam int PERIOD_WIDTH         = 8;
   localparam int CSR_INDEX_WIDTH      = 3;

   localparam int GAIN_ERROR_RESET    = 41924;
   localparam int GAIN_ACCEL_RESET    = 18575;
   localparam int MAX_STEP_RESET      = 205;
   localparam int VEHICLE_MASS_RESET  = 1500;
   localparam int UPDATE_PERIOD_RESET = 7;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_ERROR    = 3'd0,
      CSR_GAIN_ACCEL    = 3'd1,
      CSR_MAX_STEP      = 3'd2,
      CSR_VEHICLE_MASS  = 3'd3,
      CSR_UPDATE_PERIOD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_ERROR = 2'd0,
      MUL_ACCEL = 2'd1,
      MUL_FORCE = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        ready;
      logic        halt;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        term_en;
      logic        desired_en;
      logic        slew_en;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic accepted;
      logic halted;
      logic update;
      logic run;
      logic rsp_free;
   } status_type;

endpackage

// File: sv/lqrsc_if.sv
// ----------------------------------------------------------------------------
// lqrsc_req_if / lqrsc_rsp_if
// Valid/ready channels for control ticks and force commands.
// ----------------------------------------------------------------------------
interface lqrsc_req_if #(
   parameter int SIGNAL_WIDTH = lqrsc_pkg::SIGNAL_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic signed [SIGNAL_WIDTH-1:0] speed_error;
   logic signed [SIGNAL_WIDTH-1:0] measured_accel;
   logic signed [SIGNAL_WIDTH-1:0] reference_speed;
   logic signed [SIGNAL_WIDTH-1:0] ego_speed;
   logic                           run_enable;

   modport source (output valid, speed_error, measured_accel, reference_speed,
                   ego_speed, run_enable, input ready);
   modport sink   (input valid, speed_error, measured_accel, reference_speed,
                   ego_speed, run_enable, output ready);
endinterface

interface lqrsc_rsp_if #(
   parameter int SIGNAL_WIDTH = lqrsc_pkg::SIGNAL_WIDTH_DEFAULT
);
   logic                                                   valid;
   logic                                                   ready;
   logic signed [SIGNAL_WIDTH+lqrsc_pkg::MASS_WIDTH-1:0]   force_command;
   logic signed [SIGNAL_WIDTH-1:0]                         accel_command;

   modport source (output valid, force_command, accel_command, input ready);
   modport sink   (input valid, force_command, accel_command, output ready);
endinterface

// File: sv/lqrsc_ctrl.sv
// ----------------------------------------------------------------------------
// lqrsc_ctrl
// Sequencer: orders the shared multiplier, the feedback sum, the slew step
// and the result load for accepted transactions, and issues the halt.
// ----------------------------------------------------------------------------
module lqrsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  lqrsc_pkg::status_type status,
   output lqrsc_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CHECK = 8'b0000_0010,
      ST_MUL_E = 8'b0000_0100,
      ST_MUL_A = 8'b0000_1000,
      ST_SUM   = 8'b0001_0000,
      ST_SLEW  = 8'b0010_0000,
      ST_FORCE = 8'b0100_0000,
      ST_LOAD  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.mul_sel    = lqrsc_pkg::MUL_ERROR;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (status.accepted && !status.halted) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.update) begin
               state_in = ST_SLEW;
            end else if (!status.run) begin
               cmd.halt = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL_E;
            end
         end
         ST_MUL_E: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lqrsc_pkg::MUL_ERROR;
            state_in    = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.term_en = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lqrsc_pkg::MUL_ACCEL;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.desired_en = 1'b1;
            state_in       = ST_SLEW;
         end
         ST_SLEW: begin
            cmd.slew_en = 1'b1;
            state_in    = ST_FORCE;
         end
         ST_FORCE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lqrsc_pkg::MUL_FORCE;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/lqrsc_datapath.sv
// ----------------------------------------------------------------------------
// lqrsc_datapath
// Configuration registers, tick counter, shared multiplier, feedback sum with
// saturation, jerk limiter and result register.
// ----------------------------------------------------------------------------
module lqrsc_datapath #(
   parameter int FRAC_BITS    = lqrsc_pkg::FRAC_BITS_DEFAULT,
   parameter int SIGNAL_WIDTH = lqrsc_pkg::SIGNAL_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [lqrsc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [SIGNAL_WIDTH-1:0]                 csr_wdata,
   lqrsc_req_if.sink                               req,
   lqrsc_rsp_if.source                             rsp,
   input  lqrsc_pkg::cmd_type                      cmd,
   output lqrsc_pkg::status_type                   status
);

   localparam int SW   = SIGNAL_WIDTH;
   localparam int MW   = lqrsc_pkg::MASS_WIDTH;
   localparam int PRW  = lqrsc_pkg::PERIOD_WIDTH;
   localparam int PW   = 2 * SW + 1;
   localparam int SUMW = PW + 2;

   logic signed [SW-1:0]  gain_error_ff;
   logic signed [SW-1:0]  gain_accel_ff;
   logic [SW-2:0]         max_step_ff;
   logic [MW-1:0]         mass_ff;
   logic [PRW-1:0]        period_ff;

   logic signed [SW-1:0]  err_ff;
   logic signed [SW-1:0]  acc_ff;
   logic signed [SW-1:0]  ref_ff;
   logic signed [SW-1:0]  ego_ff;
   logic                  run_ff;
   logic                  update_ff;
   logic                  halted_ff;
   logic [PRW-1:0]        tick_ff;

   logic signed [PW-1:0]  prod_ff;
   logic signed [PW-1:0]  term_ff;
   logic signed [SW-1:0]  desired_ff;
   logic signed [SW-1:0]  last_ff;

   logic                  rsp_valid_ff;
   logic signed [SW+MW-1:0] rsp_force_ff;
   logic signed [SW-1:0]  rsp_accel_ff;

   logic                  accepted;
   logic [PRW:0]          tick_next;
   logic [PRW:0]          period_eff;
   logic                  update_in;
   logic signed [SW-1:0]  mul_a;
   logic signed [SW:0]    mul_b;
   logic signed [SUMW-1:0] sum;
   logic signed [SW-1:0]  desired_in;
   logic signed [SW:0]    diff;
   logic signed [SW:0]    step;
   logic signed [SW-1:0]  last_in;

   assign req.ready = cmd.ready;
   assign accepted  = req.valid && cmd.ready;

   assign tick_next  = {1'b0, tick_ff} + (PRW+1)'(1);
   assign period_eff = (period_ff == '0) ? (PRW+1)'(1) : {1'b0, period_ff};
   assign update_in  = (tick_next >= period_eff);

   always_comb begin
      unique case (cmd.mul_sel)
         lqrsc_pkg::MUL_ERROR: begin
            mul_a = gain_error_ff;
            mul_b = (SW+1)'(err_ff);
         end
         lqrsc_pkg::MUL_ACCEL: begin
            mul_a = gain_accel_ff;
            mul_b = (SW+1)'(acc_ff);
         end
         lqrsc_pkg::MUL_FORCE: begin
            mul_a = last_ff;
            mul_b = $signed({{(SW+1-MW){1'b0}}, mass_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      sum = (SUMW'(ref_ff) - SUMW'(ego_ff)) - SUMW'(term_ff)
            - SUMW'(prod_ff >>> FRAC_BITS);
      if ((&sum[SUMW-1:SW-1]) || !(|sum[SUMW-1:SW-1])) begin
         desired_in = sum[SW-1:0];
      end else if (sum[SUMW-1]) begin
         desired_in = {1'b1, {(SW-1){1'b0}}};
      end else begin
         desired_in = {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_comb begin
      diff = (SW+1)'(desired_ff) - (SW+1)'(last_ff);
      step = $signed({2'b00, max_step_ff});
      priority if (diff > step) begin
         last_in = SW'((SW+1)'(last_ff) + step);
      end else if (diff < -step) begin
         last_in = SW'((SW+1)'(last_ff) - step);
      end else begin
         last_in = desired_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_error_ff <= SW'(lqrsc_pkg::GAIN_ERROR_RESET);
         gain_accel_ff <= SW'(lqrsc_pkg::GAIN_ACCEL_RESET);
         max_step_ff   <= (SW-1)'(lqrsc_pkg::MAX_STEP_RESET);
         mass_ff       <= MW'(lqrsc_pkg::VEHICLE_MASS_RESET);
         period_ff     <= PRW'(lqrsc_pkg::UPDATE_PERIOD_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            lqrsc_pkg::CSR_GAIN_ERROR:    gain_error_ff <= csr_wdata;
            lqrsc_pkg::CSR_GAIN_ACCEL:    gain_accel_ff <= csr_wdata;
            lqrsc_pkg::CSR_MAX_STEP:      max_step_ff   <= csr_wdata[SW-2:0];
            lqrsc_pkg::CSR_VEHICLE_MASS:  mass_ff       <= csr_wdata[MW-1:0];
            lqrsc_pkg::CSR_UPDATE_PERIOD: period_ff     <= csr_wdata[PRW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         update_ff    <= 1'b0;
         halted_ff    <= 1'b0;
         desired_ff   <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accepted && !halted_ff) begin
            update_ff <= update_in;
            tick_ff   <= update_in ? '0 : tick_next[PRW-1:0];
         end
         if (cmd.halt) begin
            halted_ff <= 1'b1;
         end
         if (cmd.desired_en) begin
            desired_ff <= desired_in;
         end
         if (cmd.slew_en) begin
            last_ff <= last_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accepted) begin
         err_ff <= req.speed_error;
         acc_ff <= req.measured_accel;
         ref_ff <= req.reference_speed;
         ego_ff <= req.ego_speed;
         run_ff <= req.run_enable;
      end
      if (cmd.mul_en) begin
         prod_ff <= PW'(mul_a * mul_b);
      end
      if (cmd.term_en) begin
         term_ff <= prod_ff >>> FRAC_BITS;
      end
      if (cmd.rsp_load) begin
         rsp_force_ff <= prod_ff[SW+MW-1:0];
         rsp_accel_ff <= last_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.force_command = rsp_force_ff;
   assign rsp.accel_command = rsp_accel_ff;

   assign status.accepted = accepted;
   assign status.halted   = halted_ff;
   assign status.update   = update_ff;
   assign status.run      = run_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp.ready;

endmodule

// File: sv/lqr_speed_control_with_jerk_limit.sv
// ----------------------------------------------------------------------------
// lqr_speed_control_with_jerk_limit
// LQR speed feedback with jerk-limited acceleration and force output.
// ----------------------------------------------------------------------------
// Sequence: a plain tick runs CHECK, SLEW, FORCE and LOAD after accept; an update
//   tick adds MUL_E, MUL_A and SUM after CHECK; the result is registered in LOAD.
// Input is taken only in IDLE; the single shared multiplier does both gains and force.
// A result still held by the receiver stalls the next result load and the input.
// The halting transaction goes CHECK then IDLE; later ones are taken, with no result.
// Reset: synchronous; clears state, loads default gains, step limit, mass and period.
module lqr_speed_control_with_jerk_limit #(
   parameter int FRAC_BITS    = lqrsc_pkg::FRAC_BITS_DEFAULT,
   parameter int SIGNAL_WIDTH = lqrsc_pkg::SIGNAL_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [lqrsc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [SIGNAL_WIDTH-1:0]                 csr_wdata,
   lqrsc_req_if.sink                               req_bus,
   lqrsc_rsp_if.source                             rsp_bus
);

   lqrsc_pkg::cmd_type    cmd;
   lqrsc_pkg::status_type status;

   lqrsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lqrsc_datapath #(
      .FRAC_BITS    (FRAC_BITS),
      .SIGNAL_WIDTH (SIGNAL_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .cmd       (cmd),
      .status    (status)
   );

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halted state left without reset");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result register overwritten while pending");

   a_halt_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.halt |-> (status.update && !status.run && !status.halted))
      else $error("halt issued outside a stopped update tick");

endmodule
